[hw/rtl/lif_pkg.sv]
// Shared package for the leaky integrate-and-fire neuron step core.
// Holds field widths, register codes, reset values, FSM states and
// the structs passed between the config, multiplier and core modules.
`timescale 1ns / 1ps
`default_nettype none

package lif_pkg;

  // Field widths
  localparam int V_W        = 16;            // Q8.8 voltage
  localparam int ACC_W      = 24;            // Q16.8 current
  localparam int COEF_W     = 16;            // Q0.16 coefficients
  localparam int REFR_W     = 8;             // refractory tick count
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Serial multiplier: signed multiplicand times unsigned Q0.16 coefficient
  localparam int MUL_A_W    = 26;            // holds v_inf - V
  localparam int MUL_HI_W   = MUL_A_W + 1;
  localparam int MUL_P_W    = MUL_HI_W + COEF_W;
  localparam int MUL_CNT_W  = $clog2(COEF_W + 1);
  localparam int STEP_W     = MUL_P_W - COEF_W;   // product rounded to Q19.8
  localparam int VSUM_W     = STEP_W + 1;

  // Register reset values
  localparam logic [COEF_W-1:0]       RST_DT_OVER_TAU   = 16'd8738;
  localparam logic [COEF_W-1:0]       RST_RESISTANCE    = 16'd3277;
  localparam logic signed [V_W-1:0]   RST_V_REST        = -16'sd17920;
  localparam logic signed [V_W-1:0]   RST_V_AFTER_SPIKE = -16'sd19200;
  localparam logic signed [V_W-1:0]   RST_V_THRESHOLD   = -16'sd12800;
  localparam logic [REFR_W-1:0]       RST_REFR_TICKS    = 8'd2;
  localparam logic signed [V_W-1:0]   RST_V_INITIAL     = -16'sd17920;

  // Accumulator and membrane saturation limits
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [V_W-1:0]   V_MAX   = {1'b0, {(V_W-1){1'b1}}};
  localparam logic signed [V_W-1:0]   V_MIN   = {1'b1, {(V_W-1){1'b0}}};

  // Configuration register codes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DT_OVER_TAU   = 3'd0,
    CFG_RESISTANCE    = 3'd1,
    CFG_V_REST        = 3'd2,
    CFG_V_AFTER_SPIKE = 3'd3,
    CFG_V_THRESHOLD   = 3'd4,
    CFG_REFR_TICKS    = 3'd5,
    CFG_V_INITIAL     = 3'd6
  } lif_cfg_idx_t;

  // Request codes
  typedef enum logic {
    REQ_INJECT = 1'b0,
    REQ_TICK   = 1'b1
  } lif_req_t;

  // Core sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_RI,
    ST_DIFF,
    ST_MUL_STEP,
    ST_FIN,
    ST_EMIT
  } lif_state_t;

  // Configuration view handed to the core
  typedef struct packed {
    logic [COEF_W-1:0]       dt_over_tau;
    logic [COEF_W-1:0]       resistance;
    logic signed [V_W-1:0]   v_rest;
    logic signed [V_W-1:0]   v_after_spike;
    logic signed [V_W-1:0]   v_threshold;
    logic [REFR_W-1:0]       refractory_ticks;
    logic                    vinit_load;
    logic signed [V_W-1:0]   vinit_value;
  } lif_cfg_t;

  // Multiplier request and response
  typedef struct packed {
    logic                      start;
    logic signed [MUL_A_W-1:0] mcand;
    logic [COEF_W-1:0]         mplier;
  } lif_mul_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [MUL_P_W-1:0] prod;
  } lif_mul_rsp_t;

endpackage

`default_nettype wire

[hw/rtl/lif_if.sv]
// Valid/ready channel interfaces for the neuron step core.
// Depends on lif_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lif_in_if;
  logic                            valid;
  logic                            ready;
  logic                            req_type;
  logic signed [lif_pkg::ACC_W-1:0] current_in;

  modport source (output valid, output req_type, output current_in, input ready);
  modport sink   (input valid, input req_type, input current_in, output ready);
endinterface

interface lif_out_if;
  logic                           valid;
  logic                           ready;
  logic                           spike;
  logic signed [lif_pkg::V_W-1:0] membrane;
  logic                           in_refractory;

  modport source (output valid, output spike, output membrane, output in_refractory,
                  input ready);
  modport sink   (input valid, input spike, input membrane, input in_refractory,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/lif_cfg.sv]
// Configuration register file for the neuron step core.
// Depends on lif_pkg; presents the registers as one lif_cfg_t struct.
`timescale 1ns / 1ps
`default_nettype none

module lif_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [lif_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lif_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output lif_pkg::lif_cfg_t                     cfg
);

  logic [lif_pkg::COEF_W-1:0]     dt_r, dt_nxt;
  logic [lif_pkg::COEF_W-1:0]     res_r, res_nxt;
  logic signed [lif_pkg::V_W-1:0] v_rest_r, v_rest_nxt;
  logic signed [lif_pkg::V_W-1:0] v_after_r, v_after_nxt;
  logic signed [lif_pkg::V_W-1:0] v_thr_r, v_thr_nxt;
  logic [lif_pkg::REFR_W-1:0]     refr_r, refr_nxt;
  logic                           vinit_load;

  // Decode a write
  always_comb begin
    dt_nxt      = dt_r;
    res_nxt     = res_r;
    v_rest_nxt  = v_rest_r;
    v_after_nxt = v_after_r;
    v_thr_nxt   = v_thr_r;
    refr_nxt    = refr_r;
    vinit_load  = 1'b0;
    if (cfg_we) begin
      unique case (lif_pkg::lif_cfg_idx_t'(cfg_index))
        lif_pkg::CFG_DT_OVER_TAU:   dt_nxt      = cfg_wdata[lif_pkg::COEF_W-1:0];
        lif_pkg::CFG_RESISTANCE:    res_nxt     = cfg_wdata[lif_pkg::COEF_W-1:0];
        lif_pkg::CFG_V_REST:        v_rest_nxt  = $signed(cfg_wdata[lif_pkg::V_W-1:0]);
        lif_pkg::CFG_V_AFTER_SPIKE: v_after_nxt = $signed(cfg_wdata[lif_pkg::V_W-1:0]);
        lif_pkg::CFG_V_THRESHOLD:   v_thr_nxt   = $signed(cfg_wdata[lif_pkg::V_W-1:0]);
        lif_pkg::CFG_REFR_TICKS:    refr_nxt    = cfg_wdata[lif_pkg::REFR_W-1:0];
        lif_pkg::CFG_V_INITIAL:     vinit_load  = 1'b1;
        default:                    vinit_load  = 1'b0;   // unmapped index: drop
      endcase
    end
  end

  // Hold the registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r      <= lif_pkg::RST_DT_OVER_TAU;
      res_r     <= lif_pkg::RST_RESISTANCE;
      v_rest_r  <= lif_pkg::RST_V_REST;
      v_after_r <= lif_pkg::RST_V_AFTER_SPIKE;
      v_thr_r   <= lif_pkg::RST_V_THRESHOLD;
      refr_r    <= lif_pkg::RST_REFR_TICKS;
    end else begin
      dt_r      <= dt_nxt;
      res_r     <= res_nxt;
      v_rest_r  <= v_rest_nxt;
      v_after_r <= v_after_nxt;
      v_thr_r   <= v_thr_nxt;
      refr_r    <= refr_nxt;
    end
  end

  // The initial membrane value goes straight to the core on its write
  always_comb begin
    cfg.dt_over_tau      = dt_r;
    cfg.resistance       = res_r;
    cfg.v_rest           = v_rest_r;
    cfg.v_after_spike    = v_after_r;
    cfg.v_threshold      = v_thr_r;
    cfg.refractory_ticks = refr_r;
    cfg.vinit_load       = vinit_load;
    cfg.vinit_value      = $signed(cfg_wdata[lif_pkg::V_W-1:0]);
  end

endmodule

`default_nettype wire

[hw/rtl/lif_mul.sv]
// Bit-serial shift-add multiplier: signed multiplicand times unsigned
// Q0.16 coefficient, one coefficient bit per cycle. Depends on lif_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lif_mul (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire lif_pkg::lif_mul_req_t req,
  output lif_pkg::lif_mul_rsp_t rsp
);

  logic signed [lif_pkg::MUL_A_W-1:0]  mcand_r;
  logic [lif_pkg::MUL_HI_W-1:0]        hi_r, hi_nxt;
  logic [lif_pkg::COEF_W-1:0]          lo_r, lo_nxt;
  logic [lif_pkg::MUL_CNT_W-1:0]       cnt_r;
  logic                                done_r;
  logic [lif_pkg::MUL_HI_W-1:0]        addend;
  logic [lif_pkg::MUL_HI_W:0]          sum;

  // One shift-add step: add the multiplicand on a set bit, shift right
  always_comb begin
    addend = lo_r[0] ? {mcand_r[lif_pkg::MUL_A_W-1], mcand_r} : '0;
    sum    = {hi_r[lif_pkg::MUL_HI_W-1], hi_r} + {addend[lif_pkg::MUL_HI_W-1], addend};
    hi_nxt = sum[lif_pkg::MUL_HI_W:1];
    lo_nxt = {sum[0], lo_r[lif_pkg::COEF_W-1:1]};
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (req.start) begin
      cnt_r  <= lif_pkg::MUL_CNT_W'(lif_pkg::COEF_W);
      done_r <= 1'b0;
    end else begin
      if (cnt_r != '0) cnt_r <= cnt_r - lif_pkg::MUL_CNT_W'(1);
      done_r <= (cnt_r == lif_pkg::MUL_CNT_W'(1));
    end
  end

  // Operand and partial product shift registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      mcand_r <= req.mcand;
      hi_r    <= '0;
      lo_r    <= req.mplier;
    end else if (cnt_r != '0) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  always_comb begin
    rsp.done = done_r;
    rsp.prod = $signed({hi_r, lo_r});
  end

endmodule

`default_nettype wire

[hw/rtl/lif_neuron_step_core.sv]
// Top level of the leaky integrate-and-fire neuron step core.
// Depends on lif_pkg, lif_if, lif_cfg and lif_mul.
//
//  channel   direction  handshake          payload
//  in_ch     sink       valid/ready        req_type, current_in
//  out_ch    source     valid/ready        spike, membrane, in_refractory
//  cfg_*     input      cfg_we only        cfg_index, cfg_wdata
//
// An inject is added, saturating, to the accumulator on its transfer. A refractory
// tick goes straight to ST_EMIT, which loads the output register. An integrating
// tick makes two passes of the bit-serial multiplier (R*I, then the leak step)
// plus the steps of product capture, restart, clamp and output load. One item
// is in work at a time; the next is taken the cycle after that load, and a
// finished tick waits in its last state while the output register is still full.
// Reset (rst_n low, synchronous) loads the register defaults and v_initial.
`timescale 1ns / 1ps
`default_nettype none

module lif_neuron_step_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  lif_in_if.sink                              in_ch,
  lif_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [lif_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lif_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  lif_pkg::lif_cfg_t      cfg;
  lif_pkg::lif_mul_req_t  mul_req;
  lif_pkg::lif_mul_rsp_t  mul_rsp;
  lif_pkg::lif_state_t    state_r, state_nxt;

  logic signed [lif_pkg::V_W-1:0]     membrane_v_r;
  logic signed [lif_pkg::ACC_W-1:0]   acc_r;
  logic [lif_pkg::REFR_W-1:0]         refr_left_r;
  logic                               spike_pend_r;
  logic signed [lif_pkg::ACC_W-1:0]   ri_r;
  logic signed [lif_pkg::STEP_W-1:0]  step_r;

  logic                               out_valid_r;
  logic                               out_spike_r;
  logic signed [lif_pkg::V_W-1:0]     out_membrane_r;
  logic                               out_refr_r;

  logic                               in_xfer;
  logic                               is_tick;
  logic                               refr_busy;
  logic                               emit_go;
  logic [lif_pkg::ACC_W:0]            inj_sum;
  logic signed [lif_pkg::ACC_W-1:0]   inj_sat;
  logic [lif_pkg::STEP_W-1:0]         prod_rnd;
  logic [lif_pkg::MUL_A_W-1:0]        diff;
  logic [lif_pkg::VSUM_W-1:0]         v_sum;
  logic signed [lif_pkg::V_W-1:0]     v_clamp;
  logic                               fire;

  lif_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lif_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  // Saturating accumulate for inject items
  always_comb begin
    inj_sum = {acc_r[lif_pkg::ACC_W-1], acc_r}
            + {in_ch.current_in[lif_pkg::ACC_W-1], in_ch.current_in};
    if (inj_sum[lif_pkg::ACC_W] != inj_sum[lif_pkg::ACC_W-1]) begin
      inj_sat = inj_sum[lif_pkg::ACC_W] ? lif_pkg::ACC_MIN : lif_pkg::ACC_MAX;
    end else begin
      inj_sat = $signed(inj_sum[lif_pkg::ACC_W-1:0]);
    end
  end

  // Round a Q19.24 product to Q19.8, half up
  always_comb begin
    prod_rnd = mul_rsp.prod[lif_pkg::MUL_P_W-1:lif_pkg::COEF_W]
             + lif_pkg::STEP_W'(mul_rsp.prod[lif_pkg::COEF_W-1]);
  end

  // v_inf - V, the multiplicand of the leak step
  always_comb begin
    diff = {{(lif_pkg::MUL_A_W-lif_pkg::V_W){cfg.v_rest[lif_pkg::V_W-1]}}, cfg.v_rest}
         + {{(lif_pkg::MUL_A_W-lif_pkg::ACC_W){ri_r[lif_pkg::ACC_W-1]}}, ri_r}
         - {{(lif_pkg::MUL_A_W-lif_pkg::V_W){membrane_v_r[lif_pkg::V_W-1]}}, membrane_v_r};
  end

  // New membrane: add the step, clamp to 16 bits, test the threshold
  always_comb begin
    v_sum = {step_r[lif_pkg::STEP_W-1], step_r}
          + {{(lif_pkg::VSUM_W-lif_pkg::V_W){membrane_v_r[lif_pkg::V_W-1]}}, membrane_v_r};
    if (!v_sum[lif_pkg::VSUM_W-1] &&
        (v_sum[lif_pkg::VSUM_W-2:lif_pkg::V_W-1] != '0)) begin
      v_clamp = lif_pkg::V_MAX;
    end else if (v_sum[lif_pkg::VSUM_W-1] &&
                 (v_sum[lif_pkg::VSUM_W-2:lif_pkg::V_W-1] != '1)) begin
      v_clamp = lif_pkg::V_MIN;
    end else begin
      v_clamp = $signed(v_sum[lif_pkg::V_W-1:0]);
    end
    fire = (v_clamp >= cfg.v_threshold);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lif_pkg::ST_IDLE: begin
        if (in_xfer && is_tick) begin
          state_nxt = refr_busy ? lif_pkg::ST_EMIT : lif_pkg::ST_MUL_RI;
        end
      end
      lif_pkg::ST_MUL_RI:   if (mul_rsp.done) state_nxt = lif_pkg::ST_DIFF;
      lif_pkg::ST_DIFF:     state_nxt = lif_pkg::ST_MUL_STEP;
      lif_pkg::ST_MUL_STEP: if (mul_rsp.done) state_nxt = lif_pkg::ST_FIN;
      lif_pkg::ST_FIN:      state_nxt = lif_pkg::ST_EMIT;
      lif_pkg::ST_EMIT:     if (emit_go) state_nxt = lif_pkg::ST_IDLE;
      default:              state_nxt = lif_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ch.ready = (state_r == lif_pkg::ST_IDLE);
    in_xfer     = in_ch.valid && in_ch.ready;
    is_tick     = (lif_pkg::lif_req_t'(in_ch.req_type) == lif_pkg::REQ_TICK);
    refr_busy   = (refr_left_r != '0);
    emit_go     = (state_r == lif_pkg::ST_EMIT) && (!out_valid_r || out_ch.ready);

    mul_req.start  = (in_xfer && is_tick && !refr_busy) || (state_r == lif_pkg::ST_DIFF);
    if (state_r == lif_pkg::ST_DIFF) begin
      mul_req.mcand  = $signed(diff);
      mul_req.mplier = cfg.dt_over_tau;
    end else begin
      mul_req.mcand  = {{(lif_pkg::MUL_A_W-lif_pkg::ACC_W){acc_r[lif_pkg::ACC_W-1]}}, acc_r};
      mul_req.mplier = cfg.resistance;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= lif_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Neuron state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      membrane_v_r <= lif_pkg::RST_V_INITIAL;
      acc_r        <= '0;
      refr_left_r  <= '0;
      spike_pend_r <= 1'b0;
    end else begin
      if (cfg.vinit_load) membrane_v_r <= cfg.vinit_value;
      if (in_xfer) begin
        if (is_tick) begin
          acc_r        <= '0;
          spike_pend_r <= 1'b0;
          if (refr_busy) begin
            refr_left_r  <= refr_left_r - lif_pkg::REFR_W'(1);
            membrane_v_r <= cfg.v_after_spike;
          end
        end else begin
          acc_r <= inj_sat;
        end
      end
      if (state_r == lif_pkg::ST_FIN) begin
        if (fire) begin
          spike_pend_r <= 1'b1;
          membrane_v_r <= cfg.v_after_spike;
          refr_left_r  <= cfg.refractory_ticks;
        end else begin
          membrane_v_r <= v_clamp;
        end
      end
    end
  end

  // Capture the rounded products
  always_ff @(posedge clk) begin
    if ((state_r == lif_pkg::ST_MUL_RI) && mul_rsp.done) begin
      ri_r <= $signed(prod_rnd[lif_pkg::ACC_W-1:0]);
    end
    if ((state_r == lif_pkg::ST_MUL_STEP) && mul_rsp.done) begin
      step_r <= $signed(prod_rnd);
    end
  end

  // Output register: load on emit, drop after the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_spike_r    <= spike_pend_r;
      out_membrane_r <= membrane_v_r;
      out_refr_r     <= refr_busy;
    end
  end

  always_comb begin
    out_ch.valid         = out_valid_r;
    out_ch.spike         = out_spike_r;
    out_ch.membrane      = out_membrane_r;
    out_ch.in_refractory = out_refr_r;
  end

endmodule

`default_nettype wire

[hw/rtl/lif_neuron_step_chk.sv]
// Port-level checker for the neuron step core, attached by bind.
// Depends on the ports of lif_neuron_step_core only.
`timescale 1ns / 1ps
`default_nettype none

module lif_neuron_step_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_req_type,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_membrane,
  input wire logic        out_spike
);

  // A waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // A waiting result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_membrane) && $stable(out_spike))
    else $error("result payload changed while stalled");

  // An inject never produces a result
  a_inject_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_req_type && !out_valid |=> !out_valid)
    else $error("result appeared after an inject");

  // A tick occupies the core for at least the next cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type |=> !in_ready)
    else $error("input taken right after a tick");

endmodule

bind lif_neuron_step_core lif_neuron_step_chk u_lif_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_req_type  (in_ch.req_type),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_membrane (out_ch.membrane),
  .out_spike    (out_ch.spike)
);

`default_nettype wire
